@@ sv/ptt_pkg.sv @@
// Shared types and constants for the periodic task table.
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = 4;
    localparam int CODE_W    = 5;
    localparam int EVENT_W   = 8;
    localparam int RATE_W    = 16;
    localparam int ARG_W     = 16;
    localparam int DIV_STEPS = RATE_W;
    localparam int STEP_W    = 5;

    localparam logic [CODE_W-1:0] INVALID_SLOT = CODE_W'(NUM_SLOTS);

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_LOAD   = 3'd1;
    localparam logic [2:0] MODE_UNLOAD = 3'd2;
    localparam logic [2:0] MODE_RUN    = 3'd3;
    localparam logic [2:0] MODE_FREQ   = 3'd4;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic tick_latch;
        logic emit_fire;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic in_tick;
        logic in_div;
        logic fire_pending;
        logic out_free;
    } sts_t;

endpackage

@@ sv/ptt_datapath.sv @@
// Datapath: slot table, divider, tick scan and output register.
`timescale 1ns / 1ps

module ptt_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic [63:0]         s_tdata,
    input  logic [2:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [55:0]         m_tdata,
    output logic [0:0]          m_tuser,
    output logic                m_tlast,
    input  ptt_pkg::cmd_t       cmd,
    output ptt_pkg::sts_t       sts
);

    localparam int N = ptt_pkg::NUM_SLOTS;

    logic [15:0]                      tf_reg;
    logic [N-1:0]                     used_reg;
    logic [N-1:0]                     run_reg;
    logic [ptt_pkg::RATE_W-1:0]       cnt_reg [N];
    logic [ptt_pkg::RATE_W-1:0]       per_reg [N];
    logic [1:0]                       argc_reg [N];
    logic [ptt_pkg::EVENT_W-1:0]      ev_reg [N];
    logic [ptt_pkg::ARG_W-1:0]        arg0_reg [N];
    logic [ptt_pkg::ARG_W-1:0]        arg1_reg [N];
    logic [ptt_pkg::CODE_W-1:0]       count_reg;
    logic [N-1:0]                     fire_reg;

    logic [2:0]                       in_mode_reg;
    logic [ptt_pkg::CODE_W-1:0]       in_slot_reg;
    logic [ptt_pkg::EVENT_W-1:0]      in_ev_reg;
    logic [ptt_pkg::RATE_W-1:0]       in_rate_reg;
    logic                             in_run_reg;
    logic [1:0]                       in_argc_reg;
    logic [ptt_pkg::ARG_W-1:0]        in_a1_reg;
    logic [ptt_pkg::ARG_W-1:0]        in_a2_reg;

    logic [ptt_pkg::RATE_W-1:0]       quo_reg;
    logic [ptt_pkg::RATE_W-1:0]       rem_reg;

    logic                             ov_reg;
    logic                             o_kind_reg;
    logic [ptt_pkg::CODE_W-1:0]       o_slot_reg;
    logic [ptt_pkg::EVENT_W-1:0]      o_ev_reg;
    logic [1:0]                       o_argc_reg;
    logic [ptt_pkg::ARG_W-1:0]        o_a1_reg;
    logic [ptt_pkg::ARG_W-1:0]        o_a2_reg;
    logic                             o_ok_reg;
    logic [ptt_pkg::CODE_W-1:0]       o_count_reg;
    logic                             o_last_reg;

    logic [ptt_pkg::RATE_W:0]         div_sh;
    logic                             div_ge;
    logic [ptt_pkg::SLOT_W-1:0]       free_idx;
    logic [ptt_pkg::SLOT_W-1:0]       fire_idx;
    logic [N-1:0]                     fire_bit;
    logic [ptt_pkg::SLOT_W-1:0]       s_idx;
    logic                             s_valid;
    logic                             load_range;
    logic                             freq_range;
    logic [1:0]                       load_argc;
    logic                             do_load;
    logic                             do_drop;
    logic                             do_run;
    logic                             do_per;
    logic                             c_ok;
    logic [ptt_pkg::CODE_W-1:0]       c_slot;
    logic [ptt_pkg::CODE_W-1:0]       c_count;

    assign s_idx      = in_slot_reg[ptt_pkg::SLOT_W-1:0];
    assign s_valid    = in_slot_reg < ptt_pkg::INVALID_SLOT;
    assign load_range = (in_rate_reg != '0) && (in_rate_reg <= tf_reg);
    assign freq_range = (in_rate_reg != '0) && (in_rate_reg < tf_reg);
    assign load_argc  = (in_argc_reg > 2'd2) ? 2'd2 : in_argc_reg;

    assign div_sh = {rem_reg, quo_reg[ptt_pkg::RATE_W-1]};
    assign div_ge = div_sh >= {1'b0, in_rate_reg};

    always_comb
    begin
        free_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = ptt_pkg::SLOT_W'(i);
            end
        end
        fire_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (fire_reg[i])
            begin
                fire_idx = ptt_pkg::SLOT_W'(i);
            end
        end
        fire_bit = '0;
        fire_bit[fire_idx] = 1'b1;
    end

    always_comb
    begin
        do_load = 1'b0;
        do_drop = 1'b0;
        do_run  = 1'b0;
        do_per  = 1'b0;
        c_ok    = 1'b0;
        c_slot  = s_valid ? in_slot_reg : ptt_pkg::INVALID_SLOT;
        c_count = count_reg;
        case (in_mode_reg)
            ptt_pkg::MODE_LOAD:
            begin
                c_slot = ptt_pkg::INVALID_SLOT;
                if (load_range && !(&used_reg))
                begin
                    do_load = 1'b1;
                    c_ok    = 1'b1;
                    c_slot  = {1'b0, free_idx};
                    c_count = count_reg + 1'b1;
                end
            end
            ptt_pkg::MODE_UNLOAD:
            begin
                if (s_valid)
                begin
                    do_drop = 1'b1;
                    c_ok    = 1'b1;
                end
            end
            ptt_pkg::MODE_RUN:
            begin
                if (s_valid && used_reg[s_idx])
                begin
                    do_run = 1'b1;
                    c_ok   = 1'b1;
                end
            end
            ptt_pkg::MODE_FREQ:
            begin
                if (s_valid && used_reg[s_idx])
                begin
                    do_per  = freq_range;
                    do_drop = !freq_range;
                    c_ok    = 1'b1;
                end
            end
            default:
            begin
                c_ok = 1'b0;
            end
        endcase
        if (do_drop && used_reg[s_idx] && count_reg != '0)
        begin
            c_count = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tf_reg    <= 16'd1000;
            used_reg  <= '0;
            run_reg   <= '0;
            count_reg <= '0;
            fire_reg  <= '0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                cnt_reg[i]  <= '0;
                per_reg[i]  <= '0;
                argc_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                tf_reg <= cfg_wdata;
            end
            if (cmd.emit_fire || cmd.commit)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ov_reg <= 1'b0;
            end
            if (cmd.tick_latch)
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (used_reg[i] && run_reg[i])
                    begin
                        fire_reg[i] <= cnt_reg[i] >= per_reg[i];
                        cnt_reg[i]  <= (cnt_reg[i] >= per_reg[i]) ? 16'd1
                                                                  : cnt_reg[i] + 16'd1;
                    end
                    else
                    begin
                        fire_reg[i] <= 1'b0;
                    end
                end
            end
            if (cmd.emit_fire)
            begin
                fire_reg <= fire_reg & ~fire_bit;
            end
            if (cmd.commit)
            begin
                count_reg <= c_count;
                if (do_load)
                begin
                    used_reg[free_idx] <= 1'b1;
                    run_reg[free_idx]  <= 1'b0;
                    per_reg[free_idx]  <= quo_reg;
                    argc_reg[free_idx] <= load_argc;
                end
                if (do_drop)
                begin
                    used_reg[s_idx] <= 1'b0;
                    run_reg[s_idx]  <= 1'b0;
                end
                if (do_run)
                begin
                    run_reg[s_idx] <= in_run_reg;
                end
                if (do_per)
                begin
                    per_reg[s_idx] <= quo_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            in_mode_reg <= s_tuser;
            in_slot_reg <= s_tdata[4:0];
            in_ev_reg   <= s_tdata[12:5];
            in_rate_reg <= s_tdata[28:13];
            in_run_reg  <= s_tdata[29];
            in_argc_reg <= s_tdata[31:30];
            in_a1_reg   <= s_tdata[47:32];
            in_a2_reg   <= s_tdata[63:48];
            quo_reg     <= tf_reg;
            rem_reg     <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[ptt_pkg::RATE_W-2:0], div_ge};
            rem_reg <= div_ge ? ptt_pkg::RATE_W'(div_sh - {1'b0, in_rate_reg})
                              : div_sh[ptt_pkg::RATE_W-1:0];
        end
        if (cmd.commit && do_load)
        begin
            ev_reg[free_idx] <= in_ev_reg;
            if (load_argc >= 2'd1)
            begin
                arg0_reg[free_idx] <= in_a1_reg;
            end
            if (load_argc >= 2'd2)
            begin
                arg1_reg[free_idx] <= in_a2_reg;
            end
        end
        if (cmd.emit_fire)
        begin
            o_kind_reg  <= 1'b1;
            o_slot_reg  <= {1'b0, fire_idx};
            o_ev_reg    <= ev_reg[fire_idx];
            o_argc_reg  <= argc_reg[fire_idx];
            o_a1_reg    <= (argc_reg[fire_idx] >= 2'd1) ? arg0_reg[fire_idx] : '0;
            o_a2_reg    <= (argc_reg[fire_idx] >= 2'd2) ? arg1_reg[fire_idx] : '0;
            o_ok_reg    <= 1'b0;
            o_count_reg <= count_reg;
            o_last_reg  <= (fire_reg & ~fire_bit) == '0;
        end
        if (cmd.commit)
        begin
            o_kind_reg  <= 1'b0;
            o_slot_reg  <= c_slot;
            o_ev_reg    <= '0;
            o_argc_reg  <= '0;
            o_a1_reg    <= '0;
            o_a2_reg    <= '0;
            o_ok_reg    <= c_ok;
            o_count_reg <= c_count;
            o_last_reg  <= 1'b1;
        end
    end

    assign sts.in_tick      = s_tuser == ptt_pkg::MODE_TICK;
    assign sts.in_div       = (s_tuser == ptt_pkg::MODE_LOAD) || (s_tuser == ptt_pkg::MODE_FREQ);
    assign sts.fire_pending = |fire_reg;
    assign sts.out_free     = !ov_reg || m_tready;

    assign m_tvalid = ov_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {3'b000, o_count_reg, o_ok_reg, o_a2_reg, o_a1_reg,
                       o_argc_reg, o_ev_reg, o_slot_reg};

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(used_reg))
        else $error("loaded count differs from used slots");

    a_run_needs_used: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg & ~used_reg) == '0)
        else $error("running slot not in use");

    a_fire_from_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_fire |-> (fire_reg != '0) && !cmd.commit)
        else $error("fire emitted with nothing pending");

endmodule

@@ sv/ptt_control.sv @@
// Controller: sequences accept, divide, tick scan and result emission.
`timescale 1ns / 1ps

module ptt_control (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  ptt_pkg::sts_t  sts,
    output ptt_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCAN,
        ST_DIV,
        ST_COMMIT
    } state_t;

    state_t                     state_reg;
    logic [ptt_pkg::STEP_W-1:0] step_reg;

    assign s_tready = state_reg == ST_IDLE;

    always_comb
    begin
        cmd            = '0;
        cmd.accept     = (state_reg == ST_IDLE) && s_tvalid;
        cmd.tick_latch = state_reg == ST_TICK;
        cmd.div_step   = state_reg == ST_DIV;
        cmd.emit_fire  = (state_reg == ST_SCAN) && sts.fire_pending && sts.out_free;
        cmd.commit     = (state_reg == ST_COMMIT) && sts.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (s_tvalid)
                    begin
                        if (sts.in_tick)
                        begin
                            state_reg <= ST_TICK;
                        end
                        else if (sts.in_div)
                        begin
                            state_reg <= ST_DIV;
                        end
                        else
                        begin
                            state_reg <= ST_COMMIT;
                        end
                    end
                end
                ST_TICK:
                begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (!sts.fire_pending)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == ptt_pkg::STEP_W'(ptt_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/periodic_task_table.sv @@
// Top level of the periodic task table.
`timescale 1ns / 1ps

// Table of 16 periodic tasks driven by command words on the input stream.
// One word is handled at a time. Load and set frequency run the 16-step
// restoring divider that forms base_rate / rate before the commit;
// unload, set run and unknown modes go straight to commit. A tick
// latches the counters and emits one fire word per fired task through the
// single output register; a stall on the output holds scan and commit.
module periodic_task_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,    // base_rate
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot[4:0] event_id[12:5] rate[28:13] run_flag[29] arg_count[31:30]
    // arg_one[47:32] arg_two[63:48]
    input  logic [63:0] s_tdata,
    input  logic [2:0]  s_tuser,      // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    // task_slot[4:0] fired_event[12:5] fired_arg_count[14:13]
    // fired_arg_one[30:15] fired_arg_two[46:31] success[47] loaded_count[52:48]
    output logic [55:0] m_tdata,
    output logic [0:0]  m_tuser,      // result_kind
    output logic        m_tlast       // last_of_run
);

    ptt_pkg::cmd_t cmd;
    ptt_pkg::sts_t sts;

    ptt_control u_control (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ptt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

@@ verif/periodic_task_table_tb.sv @@
// Testbench for the periodic task table: directed and random command words checked against a model.
`timescale 1ns / 1ps

module periodic_task_table_tb;

    typedef struct packed {
        logic        kind;
        logic [4:0]  slot;
        logic [7:0]  ev;
        logic [1:0]  cnt;
        logic [15:0] a1;
        logic [15:0] a2;
        logic        ok;
        logic [4:0]  loaded;
        logic        last;
    } task_result_t;

    class task_scoreboard;
        logic [15:0] tfreq;
        logic        used [ptt_pkg::NUM_SLOTS];
        logic        running [ptt_pkg::NUM_SLOTS];
        logic [7:0]  ev [ptt_pkg::NUM_SLOTS];
        logic [15:0] cnt [ptt_pkg::NUM_SLOTS];
        logic [15:0] period [ptt_pkg::NUM_SLOTS];
        logic [1:0]  argc [ptt_pkg::NUM_SLOTS];
        logic [15:0] args [ptt_pkg::NUM_SLOTS][2];
        logic [4:0]  loaded;
        task_result_t pending[$];
        int errors;

        function new();
            tfreq = 16'd1000;
            loaded = 0;
            errors = 0;
            for (int i = 0; i < ptt_pkg::NUM_SLOTS; i++)
            begin
                used[i] = 0; running[i] = 0; ev[i] = 0; cnt[i] = 0;
                period[i] = 0; argc[i] = 0; args[i][0] = 0; args[i][1] = 0;
            end
        endfunction

        function void free_slot(int s);
            if (used[s] && loaded > 0)
                loaded--;
            used[s] = 0;
            running[s] = 0;
        endfunction

        function task_result_t status(logic [4:0] s, logic ok);
            task_result_t r;
            r = '0;
            r.slot = s; r.ok = ok; r.loaded = loaded; r.last = 1;
            return r;
        endfunction

        function void note_word(logic [2:0] mode, logic [63:0] d);
            logic [4:0]  slot;
            logic [15:0] rate;
            logic [1:0]  ac;
            logic        valid;
            int          s;
            int          first;
            logic        ok;
            logic [4:0]  got;
            task_result_t r;
            slot = d[4:0];
            rate = d[28:13];
            ac = d[31:30];
            valid = slot < ptt_pkg::NUM_SLOTS;
            s = valid ? slot : 0;
            if (mode == ptt_pkg::MODE_TICK)
            begin
                first = pending.size();
                for (int i = 0; i < ptt_pkg::NUM_SLOTS; i++)
                begin
                    if (!used[i] || !running[i])
                        continue;
                    if (cnt[i] >= period[i])
                    begin
                        if (pending.size() > first)
                            pending[pending.size()-1].last = 0;
                        r = '0;
                        r.kind = 1; r.slot = i; r.ev = ev[i]; r.cnt = argc[i];
                        r.a1 = argc[i] > 0 ? args[i][0] : 16'd0;
                        r.a2 = argc[i] > 1 ? args[i][1] : 16'd0;
                        r.loaded = loaded; r.last = 1;
                        pending.push_back(r);
                        cnt[i] = 0;
                    end
                    cnt[i] = cnt[i] + 16'd1;
                end
            end
            else if (mode == ptt_pkg::MODE_LOAD)
            begin
                got = ptt_pkg::INVALID_SLOT;
                ok = 0;
                if (rate > 0 && rate <= tfreq)
                begin
                    for (int i = 0; i < ptt_pkg::NUM_SLOTS; i++)
                    begin
                        if (!used[i])
                        begin
                            used[i] = 1; running[i] = 0; ev[i] = d[12:5];
                            period[i] = tfreq / rate;
                            argc[i] = ac > 2 ? 2'd2 : ac;
                            if (argc[i] > 0) args[i][0] = d[47:32];
                            if (argc[i] > 1) args[i][1] = d[63:48];
                            loaded++;
                            got = i; ok = 1;
                            break;
                        end
                    end
                end
                pending.push_back(status(got, ok));
            end
            else
            begin
                ok = 0;
                if (valid)
                begin
                    if (mode == ptt_pkg::MODE_UNLOAD)
                    begin
                        free_slot(s);
                        ok = 1;
                    end
                    else if (mode == ptt_pkg::MODE_RUN && used[s])
                    begin
                        running[s] = d[29];
                        ok = 1;
                    end
                    else if (mode == ptt_pkg::MODE_FREQ && used[s])
                    begin
                        if (rate > 0 && rate < tfreq)
                            period[s] = tfreq / rate;
                        else
                            free_slot(s);
                        ok = 1;
                    end
                end
                pending.push_back(status(valid ? slot : ptt_pkg::INVALID_SLOT, ok));
            end
        endfunction

        function void check_word(task_result_t got);
            task_result_t exp_r;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word %h", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %p actual %p", exp_r, got);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [15:0] cfg_wdata = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = 0;
    logic [2:0]  s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    task_scoreboard sb;
    int  cycles = 0;
    bit  calm = 0;
    bit  hold_off = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    periodic_task_table dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always @(posedge clk)
    begin
        task_result_t r;
        if (rst_n && m_tvalid && m_tready)
        begin
            r.kind = m_tuser[0]; r.slot = m_tdata[4:0]; r.ev = m_tdata[12:5];
            r.cnt = m_tdata[14:13]; r.a1 = m_tdata[30:15]; r.a2 = m_tdata[46:31];
            r.ok = m_tdata[47]; r.loaded = m_tdata[52:48]; r.last = m_tlast;
            sb.check_word(r);
        end
    end

    always @(negedge clk)
        m_tready <= !hold_off && (calm || $urandom_range(99) >= 18);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task send_word(logic [2:0] mode, logic [4:0] slot, logic [7:0] ev,
                   logic [15:0] rate, logic runf, logic [1:0] ac,
                   logic [15:0] a1, logic [15:0] a2);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 18)
            @(negedge clk);
        s_tvalid <= 1;
        s_tuser <= mode;
        s_tdata <= {a2, a1, ac, runf, rate, ev, slot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(mode, {a2, a1, ac, runf, rate, ev, slot});
        @(negedge clk);
        s_tvalid <= 0;
    endtask

    task rand_word(bit noisy);
        logic [2:0]  mode;
        logic [15:0] rate;
        int          pick;
        pick = $urandom_range(99);
        if (noisy)
            mode = $urandom_range(7);
        else if (pick < 35)
            mode = ptt_pkg::MODE_TICK;
        else if (pick < 55)
            mode = ptt_pkg::MODE_LOAD;
        else if (pick < 75)
            mode = ptt_pkg::MODE_RUN;
        else if (pick < 87)
            mode = ptt_pkg::MODE_UNLOAD;
        else
            mode = ptt_pkg::MODE_FREQ;
        rate = noisy ? 16'($urandom) : 16'($urandom_range(1, 20) * (1 + $urandom_range(3)));
        send_word(mode, noisy ? 5'($urandom) : 5'($urandom_range(15)), 8'($urandom), rate,
                  noisy ? 1'($urandom) : ($urandom_range(9) != 0), 2'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    task settle();
        @(negedge clk);
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task set_freq(logic [15:0] f);
        cfg_we <= 1;
        cfg_wdata <= f;
        @(negedge clk);
        cfg_we <= 0;
        sb.tfreq = f;
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: defaults, extremes, each special case
        send_word(ptt_pkg::MODE_LOAD, 0, 8'hFF, 16'd0, 0, 2, 16'h1234, 16'h5678);
        send_word(ptt_pkg::MODE_LOAD, 0, 8'hFF, 16'd1001, 0, 2, 16'h1234, 16'h5678);
        send_word(ptt_pkg::MODE_LOAD, 5, 8'hFF, 16'd1000, 1, 3, 16'h8000, 16'h7FFF);
        send_word(ptt_pkg::MODE_LOAD, 0, 8'h00, 16'd250, 0, 1, 16'hFFFF, 16'hFFFF);
        send_word(ptt_pkg::MODE_LOAD, 0, 8'hA5, 16'd500, 0, 0, 16'h0000, 16'h0000);
        send_word(ptt_pkg::MODE_RUN, 0, 0, 0, 1, 0, 0, 0);
        send_word(ptt_pkg::MODE_RUN, 1, 0, 0, 1, 0, 0, 0);
        send_word(ptt_pkg::MODE_RUN, 2, 0, 0, 1, 0, 0, 0);
        send_word(ptt_pkg::MODE_RUN, 9, 0, 0, 1, 0, 0, 0);
        send_word(ptt_pkg::MODE_RUN, ptt_pkg::INVALID_SLOT, 0, 0, 1, 0, 0, 0);
        for (int i = 0; i < 6; i++)
            send_word(ptt_pkg::MODE_TICK, 5'h1F, 8'hFF, 16'hFFFF, 1, 3, 16'hFFFF, 16'hFFFF);
        send_word(ptt_pkg::MODE_FREQ, 1, 0, 16'd999, 0, 0, 0, 0);
        send_word(ptt_pkg::MODE_FREQ, 2, 0, 16'd1000, 0, 0, 0, 0);
        send_word(ptt_pkg::MODE_FREQ, 7, 0, 16'd5, 0, 0, 0, 0);
        send_word(ptt_pkg::MODE_UNLOAD, 2, 0, 0, 0, 0, 0, 0);
        send_word(ptt_pkg::MODE_UNLOAD, 16, 0, 0, 0, 0, 0, 0);
        send_word(3'd5, 3, 0, 0, 0, 0, 0, 0);
        send_word(3'd7, 5'h1F, 0, 0, 0, 0, 0, 0);
        send_word(ptt_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0);
        settle();

        set_freq(16'd1);
        send_word(ptt_pkg::MODE_LOAD, 0, 8'h11, 16'd1, 0, 2, 16'h0001, 16'h0002);
        send_word(ptt_pkg::MODE_RUN, 1, 0, 0, 1, 0, 0, 0);
        for (int i = 0; i < 20; i++)
            rand_word(0);
        settle();

        // long stall on the output while words keep arriving
        fork
            begin
                hold_off = 1;
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
        join_none
        set_freq(16'd40);
        for (int i = 0; i < 18; i++)
            send_word(ptt_pkg::MODE_LOAD, 0, 8'($urandom), 16'($urandom_range(1, 40)), 0, 2,
                      16'($urandom), 16'($urandom));
        for (int i = 0; i < 16; i++)
            send_word(ptt_pkg::MODE_RUN, 5'(i), 0, 0, 1, 0, 0, 0);
        for (int i = 0; i < 30; i++)
            send_word(ptt_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0);
        settle();

        calm = 1;
        for (int i = 0; i < 60; i++)
            rand_word(0);
        calm = 0;
        settle();

        set_freq(16'hFFFF);
        for (int i = 0; i < 80; i++)
            rand_word($urandom_range(9) < 2);
        settle();

        set_freq(16'd1000);
        for (int i = 0; i < 80; i++)
            rand_word($urandom_range(9) < 2);
        settle();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
